### sv/rth_pkg.sv
// shared types and constants for the rgb to hsv converter
package rth_pkg;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned HUE_W  = 15;
  localparam int unsigned SAT_W  = 17;
  localparam int unsigned QUO_W  = 17;
  localparam int unsigned REM_W  = 25;
  localparam logic [11:0] HUE_STEP = 12'd3840;
  localparam logic [14:0] HUE_FULL = 15'd23040;

  typedef struct packed {
    logic              valid;
    logic [REM_W-1:0]  hrem;
    logic [CH_W-1:0]   delta;
    logic [QUO_W-1:0]  hq;
    logic [REM_W-1:0]  srem;
    logic [QUO_W-1:0]  sq;
    logic [CH_W-1:0]   mx;
  } div_st_t;
endpackage

### sv/rth_if.sv
// pixel and result stream interfaces
interface rth_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rth_hsv_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [16:0] saturation;
  logic [7:0]  value;
  modport source (output valid, hue, saturation, value, input ready);
  modport sink   (input valid, hue, saturation, value, output ready);
endinterface

### sv/rth_front.sv
// first stage: max, min, delta and the two dividends
module rth_front (
  input  logic            clk,
  input  logic            rst_n,
  rth_rgb_if.sink         in_if,
  output rth_pkg::div_st_t o_st,
  input  logic            dn_ready
);
  import rth_pkg::*;

  logic [CH_W-1:0] mx, mn, dl;
  logic signed [26:0] num;
  logic signed [9:0]  diff;
  logic signed [26:0] base;
  div_st_t st_nxt;
  logic up_ready;

  always_comb begin
    mx = in_if.red;
    if (in_if.green > mx) mx = in_if.green;
    if (in_if.blue > mx) mx = in_if.blue;
    mn = in_if.red;
    if (in_if.green < mn) mn = in_if.green;
    if (in_if.blue < mn) mn = in_if.blue;
    dl = mx - mn;
    // red wins ties, then green
    if (mx == in_if.red) begin
      diff = $signed({2'b0, in_if.green}) - $signed({2'b0, in_if.blue});
      base = 27'sd0;
    end else if (mx == in_if.green) begin
      diff = $signed({2'b0, in_if.blue}) - $signed({2'b0, in_if.red});
      base = $signed(27'(2 * HUE_STEP * dl));
    end else begin
      diff = $signed({2'b0, in_if.red}) - $signed({2'b0, in_if.green});
      base = $signed(27'(4 * HUE_STEP * dl));
    end
    num = base + $signed({15'b0, HUE_STEP}) * 27'(diff);
    if (num < 0) num = num + $signed(27'(HUE_FULL * dl));
    st_nxt.valid = in_if.valid;
    st_nxt.hrem  = REM_W'(num);
    st_nxt.delta = dl;
    st_nxt.hq    = '0;
    st_nxt.srem  = REM_W'({dl, 16'b0});
    st_nxt.sq    = '0;
    st_nxt.mx    = mx;
  end

  assign up_ready    = !o_st.valid || dn_ready;
  assign in_if.ready = up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_st <= '0;
    end else if (up_ready) begin
      o_st <= st_nxt;
    end
  end
endmodule

### sv/rth_div_cell.sv
// one restoring division cell: one quotient bit for hue and one for saturation
module rth_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rth_pkg::div_st_t i_st,
  output logic             up_ready,
  output rth_pkg::div_st_t o_st,
  input  logic             dn_ready
);
  import rth_pkg::*;

  logic [REM_W-1:0] hdiv, sdiv;
  logic hbit, sbit;
  div_st_t st_nxt;

  always_comb begin
    hdiv = REM_W'(i_st.delta) << SHIFT;
    sdiv = REM_W'(i_st.mx) << SHIFT;
    // a zero divisor always gives a zero quotient
    hbit = (i_st.delta != '0) && (i_st.hrem >= hdiv);
    sbit = (i_st.mx != '0) && (i_st.srem >= sdiv);
    st_nxt       = i_st;
    st_nxt.hrem  = hbit ? i_st.hrem - hdiv : i_st.hrem;
    st_nxt.srem  = sbit ? i_st.srem - sdiv : i_st.srem;
    st_nxt.hq    = {i_st.hq[QUO_W-2:0], hbit};
    st_nxt.sq    = {i_st.sq[QUO_W-2:0], sbit};
  end

  assign up_ready = !o_st.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_st <= '0;
    end else if (up_ready) begin
      o_st <= st_nxt;
    end
  end
endmodule

### sv/rgb_to_hsv_converter.sv
// rgb to hsv converter top level: front stage and a row of divider cells
//  channel | dir | fields
//  in_if   | in  | red, green, blue (8 bits each)
//  out_if  | out | hue (15), saturation (17), value (8)
// one pixel per cycle sustained while out_if.ready stays high; front stage plus 17 cells,
// one quotient bit per cell for both divisions
// each stage stalls only when the stage after it is full and stalled
// synchronous active-low reset empties every stage
module rgb_to_hsv_converter (
  input  logic clk,
  input  logic rst_n,
  rth_rgb_if.sink   in_if,
  rth_hsv_if.source out_if
);
  import rth_pkg::*;

  div_st_t st [0:QUO_W];
  logic    rdy [0:QUO_W];

  rth_front u_front (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .o_st(st[0]), .dn_ready(rdy[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    rth_div_cell #(.SHIFT(QUO_W - 1 - i)) u_cell (
      .clk(clk), .rst_n(rst_n), .i_st(st[i]), .up_ready(rdy[i]),
      .o_st(st[i+1]), .dn_ready(rdy[i+1])
    );
  end

  assign rdy[QUO_W]        = out_if.ready;
  assign out_if.valid      = st[QUO_W].valid;
  assign out_if.hue        = st[QUO_W].hq[HUE_W-1:0];
  assign out_if.saturation = st[QUO_W].sq;
  assign out_if.value      = st[QUO_W].mx;

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> st[QUO_W].hq < QUO_W'(HUE_FULL))
    else $error("hue out of range");
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.saturation <= SAT_W'(65536))
    else $error("saturation out of range");
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.value == '0) |-> (out_if.saturation == '0 && out_if.hue == '0))
    else $error("black pixel with nonzero hue or saturation");
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && st[QUO_W].delta == '0) |-> out_if.hue == '0)
    else $error("grey pixel with nonzero hue");
endmodule

### tb/tb_top.sv
// testbench for the rgb to hsv converter: random and directed pixels, scoreboard check
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [14:0] hue;
    logic [16:0] saturation;
    logic [7:0]  value;
  } hsv_t;

  // expected hsv results in transfer order
  class hsv_scoreboard;
    hsv_t pending[$];
    int   errors;
    int   checked;

    function hsv_t convert(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      hsv_t   res;
      int     mx;
      int     mn;
      int     dl;
      int     num;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      dl = mx - mn;
      res.hue = '0;
      res.saturation = '0;
      res.value = mx[7:0];
      if (dl != 0) begin
        if (mx == r) begin
          num = 3840 * (int'(g) - int'(b));
          if (num < 0) num += 23040 * dl;
        end else if (mx == g) begin
          num = 2 * 3840 * dl + 3840 * (int'(b) - int'(r));
        end else begin
          num = 4 * 3840 * dl + 3840 * (int'(r) - int'(g));
        end
        res.hue = 15'(num / dl);
      end
      if (mx != 0) res.saturation = 17'((dl * 65536) / mx);
      return res;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pending.push_back(convert(r, g, b));
    endfunction

    function void check_result(logic [14:0] h, logic [16:0] s, logic [7:0] v);
      hsv_t e;
      if (pending.size() == 0) begin
        $error("unexpected result hue=%0d saturation=%0d value=%0d", h, s, v);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (h !== e.hue) begin
        $error("hue: expected %0d, actual %0d", e.hue, h);
        errors++;
      end
      if (s !== e.saturation) begin
        $error("saturation: expected %0d, actual %0d", e.saturation, s);
        errors++;
      end
      if (v !== e.value) begin
        $error("value: expected %0d, actual %0d", e.value, v);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  rth_rgb_if in_if();
  rth_hsv_if out_if();
  hsv_scoreboard sb = new();
  bit calm;
  int idle_cycles;
  int pixels_sent;

  rgb_to_hsv_converter dut (.clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if));

  always #5 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.red = '0;
    in_if.green = '0;
    in_if.blue = '0;
    out_if.ready = 1'b0;
  end

  // result side: random stall, check every transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.hue, out_if.saturation, out_if.value);
      out_if.ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (!calm && $urandom_range(99) < 17) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.red <= r;
    in_if.green <= g;
    in_if.blue <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_pixel(r, g, b);
    pixels_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_pixel();
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] lvl;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    lvl = 8'($urandom);
    // bias toward ties, greys and pure hues
    case ($urandom_range(9))
      0: begin r = lvl; g = lvl; b = lvl; end
      1: r = g;
      2: g = b;
      3: b = r;
      4: if ($urandom_range(1)) r = '0; else b = '0;
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  initial begin
    idle_cycles = 0;
    pixels_sent = 0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed corners
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd10, 8'd100);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd100, 8'd100, 8'd50);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd1, 8'd1, 8'd0);
    send_pixel(8'd254, 8'd255, 8'd253);
    send_pixel(8'd170, 8'd85, 8'd255);
    send_pixel(8'd10, 8'd200, 8'd9);
    drain();
    // long stretch with no idling on either side
    calm = 1'b1;
    repeat (200) random_pixel();
    calm = 1'b0;
    repeat (250) random_pixel();
    drain();
    repeat (250) random_pixel();
    drain();
    repeat (30) @(posedge clk);
    $display("converted %0d pixels (greys, ties, pure hues, random), checked %0d results",
             pixels_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
